>>> rtl/core/sdsc_pkg.sv
// ----------------------------------------------------------------------------
// sdsc_pkg
// Shared types and constants for the SD SPI command transaction core.
// ----------------------------------------------------------------------------
package sdsc_pkg;

    // Polls sent after the frame before a timeout is declared, minus one.
    localparam int unsigned POLL_LIMIT = 128;

    // Command codes of an input item.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RX    = 1'b1;

    // One input item.
    typedef struct packed {
        logic        command;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic        use_crc;
        logic [7:0]  rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [7:0] response;
        logic       timed_out;
    } t_out_item;

endpackage

>>> rtl/core/sdsc_in_if.sv
// ----------------------------------------------------------------------------
// sdsc_in_if
// Input item channel: valid/ready handshake with command item payload.
// ----------------------------------------------------------------------------
interface sdsc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        use_crc;
    logic [7:0]  rx_byte;

    modport source (
        output valid, command, cmd_index, argument, use_crc, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, command, cmd_index, argument, use_crc, rx_byte,
        output ready
    );
endinterface

>>> rtl/core/sdsc_out_if.sv
// ----------------------------------------------------------------------------
// sdsc_out_if
// Result item channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface sdsc_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [7:0] response;
    logic       timed_out;

    modport source (
        output valid, tx_valid, tx_byte, done_res, response, timed_out,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, done_res, response, timed_out,
        output ready
    );
endinterface

>>> rtl/core/sdsc_txn_fsm.sv
// ----------------------------------------------------------------------------
// sdsc_txn_fsm
// Transaction sequencer: frame generation, running CRC7, R1 polling.
// ----------------------------------------------------------------------------
module sdsc_txn_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  sdsc_pkg::t_in_item i_item,
    output sdsc_pkg::t_out_item o_res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FRAME = 2'd1;
    localparam logic [1:0] PH_POLL  = 2'd2;

    localparam logic [2:0] POS_CRC  = 3'd5;
    localparam logic [7:0] POLL_END = 8'(sdsc_pkg::POLL_LIMIT + 1);

    logic [1:0]  r_phase,    n_phase;
    logic [2:0]  r_pos,      n_pos;
    logic        r_len_six,  n_len_six;
    logic [5:0]  r_index,    n_index;
    logic [31:0] r_arg,      n_arg;
    logic [6:0]  r_crc,      n_crc;
    logic [7:0]  r_poll,     n_poll;

    logic [7:0]  w_fbyte;
    logic [2:0]  w_flen;

    // CRC7 (poly 0x09), one byte MSB first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] d);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int b = 7; b >= 0; b--) begin
            fb = d[b] ^ c[6];
            c  = {c[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
        end
        return c;
    endfunction

    always_comb begin
        case (r_pos)
            3'd0:    w_fbyte = {2'b01, r_index};
            3'd1:    w_fbyte = r_arg[31:24];
            3'd2:    w_fbyte = r_arg[23:16];
            3'd3:    w_fbyte = r_arg[15:8];
            3'd4:    w_fbyte = r_arg[7:0];
            default: w_fbyte = {r_crc, 1'b1};
        endcase
    end

    assign w_flen = r_len_six ? 3'd6 : 3'd5;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len_six = r_len_six;
        n_index   = r_index;
        n_arg     = r_arg;
        n_crc     = r_crc;
        n_poll    = r_poll;

        o_res.tx_valid  = 1'b0;
        o_res.tx_byte   = 8'hFF;
        o_res.done_res  = 1'b0;
        o_res.response  = 8'h00;
        o_res.timed_out = 1'b0;

        if (i_item.command == sdsc_pkg::CMD_START) begin
            n_index   = i_item.cmd_index;
            n_arg     = i_item.argument;
            n_len_six = i_item.use_crc;
            n_crc     = crc7_byte(7'h00, {2'b01, i_item.cmd_index});
            n_poll    = 8'h00;
            n_phase   = PH_FRAME;
            n_pos     = 3'd1;
            o_res.tx_valid = 1'b1;
            o_res.tx_byte  = {2'b01, i_item.cmd_index};
        end else begin
            unique case (r_phase)
                PH_FRAME: begin
                    o_res.tx_valid = 1'b1;
                    if (r_pos < w_flen) begin
                        o_res.tx_byte = w_fbyte;
                        n_pos         = r_pos + 3'd1;
                        if (r_pos < POS_CRC) begin
                            n_crc = crc7_byte(r_crc, w_fbyte);
                        end
                    end else begin
                        n_phase = PH_POLL;
                        n_poll  = 8'd1;
                    end
                end
                PH_POLL: begin
                    if (i_item.rx_byte != 8'hFF) begin
                        o_res.done_res = 1'b1;
                        o_res.response = i_item.rx_byte;
                        n_phase        = PH_IDLE;
                    end else if (r_poll >= POLL_END) begin
                        o_res.done_res  = 1'b1;
                        o_res.response  = 8'hFF;
                        o_res.timed_out = 1'b1;
                        n_phase         = PH_IDLE;
                    end else begin
                        o_res.tx_valid = 1'b1;
                        n_poll         = r_poll + 8'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= 3'd0;
            r_len_six <= 1'b0;
            r_index   <= 6'd0;
            r_arg     <= 32'd0;
            r_crc     <= 7'd0;
            r_poll    <= 8'd0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_len_six <= n_len_six;
            r_index   <= n_index;
            r_arg     <= n_arg;
            r_crc     <= n_crc;
            r_poll    <= n_poll;
        end
    end

endmodule

>>> rtl/core/sd_spi_command_transaction_core.sv
// ----------------------------------------------------------------------------
// sd_spi_command_transaction_core
// Host side of one SD-card SPI command: frame, CRC7 and R1 response polling.
// ----------------------------------------------------------------------------
// One item in, one result out, every item. A start item (command = 0) latches
// the index, argument and CRC choice and returns the first frame byte; each
// later item carries the byte the card shifted back and returns the next byte
// to send (tx_valid = 1) or, at the end, done_res with the R1 response. The
// block sustains one item per clock while results are taken: an input register
// feeds the single-pass sequencer, whose result lands in an output register,
// and a stalled result does not stop the next item from being taken into the
// input register while that register is empty.
module sd_spi_command_transaction_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdsc_in_if.sink     i_in,
    sdsc_out_if.source  o_out
);

    logic                r_in_valid;
    sdsc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    sdsc_pkg::t_out_item r_out;

    sdsc_pkg::t_out_item w_res;
    logic                w_adv;   // input register hands its item on

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.command   <= i_in.command;
            r_in.cmd_index <= i_in.cmd_index;
            r_in.argument  <= i_in.argument;
            r_in.use_crc   <= i_in.use_crc;
            r_in.rx_byte   <= i_in.rx_byte;
        end
    end

    // Sequencer state advances once per item handed on
    sdsc_txn_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.tx_valid  = r_out.tx_valid;
    assign o_out.tx_byte   = r_out.tx_byte;
    assign o_out.done_res  = r_out.done_res;
    assign o_out.response  = r_out.response;
    assign o_out.timed_out = r_out.timed_out;

`ifndef SYNTHESIS
    // A timeout always finishes the transaction with an all-ones response.
    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.timed_out |-> r_out.done_res && r_out.response == 8'hFF)
        else $error("timeout without done or 0xFF response");

    // A finished transaction asks for no further byte.
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.tx_valid)
        else $error("done with tx_valid set");

    // A held input item stays until it is handed on.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("input item lost");

    // A stalled result is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");
`endif

endmodule

>>> bench/sd_spi_command_transaction_core_tb.sv
// ----------------------------------------------------------------------------
// sd_spi_command_transaction_core_tb
// Self-checking bench for the SD SPI command core. Drives start and card-byte
// items through the valid/ready channels with random idle and stall bursts.
// A scoreboard object mirrors the command sequencer (frame, CRC7 byte, 0xFF
// polling, response or timeout) and checks every result field in order.
// ----------------------------------------------------------------------------
module sd_spi_command_transaction_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEM_TARGET    = 700;
    localparam int          QUIET_TAIL     = 100;   // last items run with no idling
    localparam int          WATCHDOG_LIMIT = 500;   // cycles with no item moving
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          NO_CUT         = -1;
    localparam logic [7:0]  POLL_BYTE      = 8'hFF;
    localparam logic [7:0]  START_BITS     = 8'h40;
    localparam logic [7:0]  CRC7_POLY      = 8'h09;
    localparam logic [2:0]  LEN_PLAIN      = 3'd5;
    localparam logic [2:0]  LEN_WITH_CRC   = 3'd6;

    typedef enum logic [1:0] {PH_IDLE, PH_FRAME, PH_POLL} t_phase;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the command sequencer and holds the results it owes.
    // ------------------------------------------------------------------------
    class sd_cmd_scoreboard;
        t_phase               phase;
        logic [2:0]           frame_pos;
        logic                 frame_six;
        logic [5:0]           held_index;
        logic [31:0]          held_arg;
        logic [6:0]           held_crc;
        logic [7:0]           poll_count;
        sdsc_pkg::t_out_item  owed_q[$];
        int                   errors;
        int                   n_starts;
        int                   n_restarts;
        int                   n_responses;
        int                   n_timeouts;
        int                   n_idle_rx;

        function new();
            phase      = PH_IDLE;
            frame_pos  = '0;
            frame_six  = 1'b0;
            held_index = '0;
            held_arg   = '0;
            held_crc   = '0;
            poll_count = '0;
        endfunction

        function logic [7:0] frame_byte(logic [2:0] pos);
            case (pos)
                3'd0:    return START_BITS | {2'b00, held_index};
                3'd1:    return held_arg[31:24];
                3'd2:    return held_arg[23:16];
                3'd3:    return held_arg[15:8];
                3'd4:    return held_arg[7:0];
                default: return {held_crc, 1'b1};
            endcase
        endfunction

        // CRC7 over the five header bytes, MSB first, starting from zero
        function logic [6:0] header_crc7();
            logic [7:0] crc;
            logic [7:0] d;
            int         p;
            int         b;
            crc = '0;
            for (p = 0; p < 5; p++) begin
                d = frame_byte(3'(p));
                for (b = 0; b < 8; b++) begin
                    crc = crc << 1;
                    if ((d[7] ^ crc[7]) == 1'b1) begin
                        crc = crc ^ CRC7_POLY;
                    end
                    d = d << 1;
                end
            end
            return crc[6:0];
        endfunction

        function void note_item(sdsc_pkg::t_in_item it);
            sdsc_pkg::t_out_item res;
            res = '{tx_valid: 1'b0, tx_byte: POLL_BYTE, done_res: 1'b0,
                    response: 8'h00, timed_out: 1'b0};
            if (it.command == sdsc_pkg::CMD_START) begin
                if (phase != PH_IDLE) begin
                    n_restarts++;
                end
                n_starts++;
                held_index   = it.cmd_index;
                held_arg     = it.argument;
                frame_six    = it.use_crc;
                held_crc     = header_crc7();
                poll_count   = '0;
                phase        = PH_FRAME;
                res.tx_valid = 1'b1;
                res.tx_byte  = frame_byte(3'd0);
                frame_pos    = 3'd1;
            end else if (phase == PH_FRAME) begin
                // card byte is don't-care while the frame goes out
                res.tx_valid = 1'b1;
                if (frame_pos < (frame_six ? LEN_WITH_CRC : LEN_PLAIN)) begin
                    res.tx_byte = frame_byte(frame_pos);
                    frame_pos   = frame_pos + 3'd1;
                end else begin
                    phase      = PH_POLL;
                    poll_count = 8'd1;
                end
            end else if (phase == PH_POLL) begin
                if (it.rx_byte != POLL_BYTE) begin
                    res.done_res = 1'b1;
                    res.response = it.rx_byte;
                    phase        = PH_IDLE;
                    n_responses++;
                end else if (poll_count >= sdsc_pkg::POLL_LIMIT + 1) begin
                    res.done_res  = 1'b1;
                    res.response  = POLL_BYTE;
                    res.timed_out = 1'b1;
                    phase         = PH_IDLE;
                    n_timeouts++;
                end else begin
                    res.tx_valid = 1'b1;
                    poll_count   = poll_count + 8'd1;
                end
            end else begin
                n_idle_rx++;
            end
            owed_q.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(sdsc_pkg::t_out_item got);
            sdsc_pkg::t_out_item want;
            if (owed_q.size() == 0) begin
                report($sformatf("result %h with nothing owed", got));
                return;
            end
            want = owed_q.pop_front();
            if (got.tx_valid !== want.tx_valid)
                report($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
            if (got.response !== want.response)
                report($sformatf("response %h, want %h", got.response, want.response));
            if (got.timed_out !== want.timed_out)
                report($sformatf("timed_out %b, want %b", got.timed_out, want.timed_out));
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block under test
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    sdsc_in_if  in_ch ();
    sdsc_out_if out_ch ();

    sd_spi_command_transaction_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sd_cmd_scoreboard sb;
    bit idle_on;        // random gaps/stalls allowed
    int cmd_items;      // items that take part in a command
    int quiet_cycles;
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Present one item; optionally idle first. Returns at the accepting edge.
    task automatic send_item(logic cmd, logic [5:0] idx, logic [31:0] arg,
                             logic crc, logic [7:0] rx, bit counted);
        sdsc_pkg::t_in_item it;
        it = '{command: cmd, cmd_index: idx, argument: arg, use_crc: crc, rx_byte: rx};
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.cmd_index <= idx;
        in_ch.argument  <= arg;
        in_ch.use_crc   <= crc;
        in_ch.rx_byte   <= rx;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(it);
        if (counted) begin
            cmd_items++;
        end
    endtask

    // Card byte; the start-only fields carry junk so their bits toggle too.
    task automatic send_rx(logic [7:0] rx, bit counted);
        send_item(sdsc_pkg::CMD_RX, 6'($urandom_range(0, 63)), $urandom,
                  1'($urandom_range(0, 1)), rx, counted);
    endtask

    // One command: start, the frame (card bytes random), ff_polls idle polls,
    // then the R1 byte if send_last. cut >= 0 abandons after that many card
    // bytes so the next start lands mid-frame or mid-poll.
    task automatic run_command(logic [5:0] idx, logic [31:0] arg, logic crc,
                               int ff_polls, logic [7:0] last_rx, bit send_last,
                               int cut);
        int flen;
        int sent;
        int i;
        flen = crc ? 6 : 5;
        sent = 0;
        send_item(sdsc_pkg::CMD_START, idx, arg, crc, 8'($urandom_range(0, 255)), 1'b1);
        for (i = 0; i < flen; i++) begin
            if (sent == cut) return;
            send_rx(8'($urandom_range(0, 255)), 1'b1);
            sent++;
        end
        for (i = 0; i < ff_polls; i++) begin
            if (sent == cut) return;
            send_rx(POLL_BYTE, 1'b1);
            sent++;
        end
        if (send_last && sent != cut) begin
            send_rx(last_rx, 1'b1);
        end
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts on ready, every accepted result checked
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7);
        end
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(sdsc_pkg::t_out_item'{tx_valid: out_ch.tx_valid,
                                                  tx_byte: out_ch.tx_byte,
                                                  done_res: out_ch.done_res,
                                                  response: out_ch.response,
                                                  timed_out: out_ch.timed_out});
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int         kind;
        logic [5:0] idx;
        logic [31:0] arg;
        logic       crc;
        int         cut;

        sb           = new();
        idle_on      = 1'b1;
        cmd_items    = 0;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= sdsc_pkg::CMD_RX;
        in_ch.cmd_index <= '0;
        in_ch.argument  <= '0;
        in_ch.use_crc   <= 1'b0;
        in_ch.rx_byte   <= '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // card byte with nothing in flight
        send_rx(8'h00, 1'b0);
        // CMD0 with CRC byte, R1 on the first poll
        run_command(6'd0, 32'h0000_0000, 1'b1, 0, 8'h01, 1'b1, NO_CUT);
        // top index, all-ones argument, no CRC; cut mid-frame -> restart
        run_command(6'd63, 32'hFFFF_FFFF, 1'b0, 0, 8'h00, 1'b0, 2);
        // CMD8-like with CRC, two idle polls, R1 = 0x00
        run_command(6'd8, 32'h0000_01AA, 1'b1, 2, 8'h00, 1'b1, NO_CUT);
        // cut after two polls -> restart during polling
        run_command(6'd55, 32'h8000_0001, 1'b0, 4, 8'h7F, 1'b1, 7);
        run_command(6'd41, 32'h4000_0000, 1'b1, 1, 8'hFE, 1'b1, NO_CUT);

        // --- random ---
        // one full timeout and one response on the very last allowed poll first
        run_command(6'($urandom_range(0, 63)), pick_arg(), 1'($urandom_range(0, 1)),
                    sdsc_pkg::POLL_LIMIT + 1, 8'h00, 1'b0, NO_CUT);
        run_command(6'($urandom_range(0, 63)), pick_arg(), 1'($urandom_range(0, 1)),
                    sdsc_pkg::POLL_LIMIT, 8'($urandom_range(0, 254)), 1'b1, NO_CUT);

        while (cmd_items < ITEM_TARGET) begin
            if (cmd_items >= ITEM_TARGET - QUIET_TAIL) begin
                idle_on = 1'b0;
            end
            kind = $urandom_range(0, 99);
            idx  = 6'($urandom_range(0, 63));
            arg  = pick_arg();
            crc  = 1'($urandom_range(0, 1));
            if (kind < 2) begin
                run_command(idx, arg, crc, sdsc_pkg::POLL_LIMIT + 1, 8'h00, 1'b0, NO_CUT);
            end else if (kind < 4) begin
                run_command(idx, arg, crc, sdsc_pkg::POLL_LIMIT,
                            8'($urandom_range(0, 254)), 1'b1, NO_CUT);
            end else if (kind < 16) begin
                // broken command: abandoned anywhere up to a few polls in
                cut = $urandom_range(0, 10);
                run_command(idx, arg, crc, $urandom_range(0, 4),
                            8'($urandom_range(0, 254)), 1'b1, cut);
            end else if (kind < 22) begin
                // stray card bytes
                repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                run_command(idx, arg, crc, $urandom_range(0, 6),
                            8'($urandom_range(0, 254)), 1'b1, NO_CUT);
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d commands sent (%0d restarted in flight), %0d card items",
                 sb.n_starts, sb.n_restarts, cmd_items);
        $display("run: %0d R1 responses, %0d poll timeouts, %0d idle bytes, %0d mismatches",
                 sb.n_responses, sb.n_timeouts, sb.n_idle_rx, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
